// ===== hw/rtl/slot_allocator_free_list_core_assert.svh =====
// Assertion macros shared by the slot allocator RTL.
// SFL_ASSERT checks a property on every rising clock edge outside reset.
// SFL_ASSERT_NEVER checks that a condition is never true outside reset.
`ifndef SLOT_ALLOCATOR_FREE_LIST_CORE_ASSERT_SVH
`define SLOT_ALLOCATOR_FREE_LIST_CORE_ASSERT_SVH

`ifndef SYNTH
`define SFL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("slot allocator: property violated");
`define SFL_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("slot allocator: forbidden condition seen");
`else
`define SFL_ASSERT(lbl, clk, rst, prop)
`define SFL_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ===== hw/rtl/slot_fl_pkg.sv =====
`default_nettype none

package slot_fl_pkg;

  // default number of slots
  localparam int CAPACITY_DEF = 1024;

  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_LIVE = 2'd2;

  // free stack commands, at most one per cycle
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slot_allocator_free_list_core.sv =====
`default_nettype none
`include "slot_allocator_free_list_core_assert.svh"

// Slot allocator with LIFO reuse of freed slots.
// Input channel s_*: tuser carries the function (allocate, free, query,
// clear), tdata the slot id. Output channel m_*: one result beat per input
// beat, in order, with the granted id, status, liveness flag and live count.
// Beats pass through the input register and then the output register, one
// per cycle while m_tready is high. The input register exists because the
// active-bit RAM has a registered read; the free stack keeps its top in a
// register and prefetches the entry below, so back-to-back pops need no
// bubble. Writes that hit the slot being read are forwarded.
// Reset clears the stack depth, the high-water mark, the live count and
// both valid flags; RAM contents stay undefined and are never used before
// they are written. When the receiver holds m_tready low, the result beat
// holds, one more input beat is taken into the input register, and then
// s_tready drops until the output register drains.
module slot_allocator_free_list_core import slot_fl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int ID_W    = $clog2(CAPACITY),
  localparam int CNT_W   = $clog2(CAPACITY + 1),
  localparam int IN_W    = ((ID_W + 7) / 8) * 8,
  localparam int RES_W   = ID_W + STAT_W + 1 + CNT_W,
  localparam int OUT_W   = ((RES_W + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [IN_W-1:0]   s_tdata,   // slot_id
  input  wire logic [FUNC_W-1:0] s_tuser,   // func
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [OUT_W-1:0]  m_tdata    // granted_id, status, is_live, live_total
);

  logic              in_acc;
  logic              s0_valid;
  logic              s0_adv;
  logic [FUNC_W-1:0] s0_func;
  logic [ID_W-1:0]   s0_id;
  logic              s0_fwd;
  logic              s0_fwd_bit;

  logic              act_we;
  logic [ID_W-1:0]   act_waddr;
  logic              act_wdata;
  logic              act_rd;
  logic              act_bit;

  logic [CNT_W-1:0]  high_water;
  logic [CNT_W-1:0]  high_water_next;
  logic [CNT_W-1:0]  live_count;
  logic [CNT_W-1:0]  live_count_next;

  stack_ctl_t        ctl_raw;
  stack_ctl_t        stk_ctl;
  logic [ID_W-1:0]   stk_top;
  logic [CNT_W-1:0]  stk_depth;

  logic              slot_live;
  logic [ID_W-1:0]   granted;
  logic [STAT_W-1:0] status;
  logic              is_live;
  logic              we_raw;

  // handshake
  assign s0_adv   = s0_valid && (!m_tvalid || m_tready);
  assign s_tready = !s0_valid || s0_adv;
  assign in_acc   = s_tvalid && s_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_acc) begin
      s0_valid <= 1'b1;
    end else if (s0_adv) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_func    <= s_tuser;
      s0_id      <= s_tdata[ID_W-1:0];
      s0_fwd     <= act_we && (act_waddr == s_tdata[ID_W-1:0]);
      s0_fwd_bit <= act_wdata;
    end
  end

  // active bits, read at accept time
  slot_fl_ram #(
    .WIDTH (1),
    .DEPTH (CAPACITY)
  ) u_active_ram (
    .clk     (clk),
    .wr_en   (act_we),
    .wr_addr (act_waddr),
    .wr_data (act_wdata),
    .rd_en   (in_acc),
    .rd_addr (s_tdata[ID_W-1:0]),
    .rd_data (act_rd)
  );

  assign act_bit   = s0_fwd ? s0_fwd_bit : act_rd;
  assign slot_live = (CNT_W'(s0_id) < high_water) && act_bit;

  // free stack
  slot_fl_stack #(
    .CAPACITY (CAPACITY),
    .ID_W     (ID_W),
    .CNT_W    (CNT_W)
  ) u_stack (
    .clk     (clk),
    .rst     (rst),
    .ctl     (stk_ctl),
    .push_id (s0_id),
    .top     (stk_top),
    .depth   (stk_depth)
  );

  // execute one function
  always_comb begin
    granted         = '0;
    status          = STAT_OK;
    is_live         = 1'b0;
    ctl_raw         = '0;
    we_raw          = 1'b0;
    act_waddr       = s0_id;
    act_wdata       = 1'b0;
    high_water_next = high_water;
    live_count_next = live_count;
    case (s0_func)
      FUNC_ALLOC: begin
        if (stk_depth != '0) begin
          granted         = stk_top;
          ctl_raw.pop     = 1'b1;
          we_raw          = 1'b1;
          act_waddr       = stk_top;
          act_wdata       = 1'b1;
          live_count_next = live_count + CNT_W'(1);
        end else if (high_water != CNT_W'(CAPACITY)) begin
          granted         = high_water[ID_W-1:0];
          high_water_next = high_water + CNT_W'(1);
          we_raw          = 1'b1;
          act_waddr       = high_water[ID_W-1:0];
          act_wdata       = 1'b1;
          live_count_next = live_count + CNT_W'(1);
        end else begin
          status = STAT_FULL;
        end
      end
      FUNC_FREE: begin
        if (slot_live && (stk_depth != CNT_W'(CAPACITY))) begin
          ctl_raw.push = 1'b1;
          we_raw       = 1'b1;
          if (live_count != '0) begin
            live_count_next = live_count - CNT_W'(1);
          end
        end else begin
          status = STAT_NOT_LIVE;
        end
      end
      FUNC_QUERY: begin
        is_live = slot_live;
      end
      FUNC_CLEAR: begin
        ctl_raw.clear   = 1'b1;
        high_water_next = '0;
        live_count_next = '0;
      end
      default: begin
        status = STAT_OK;
      end
    endcase
  end

  // side effects only when the beat moves on
  assign stk_ctl = s0_adv ? ctl_raw : '0;
  assign act_we  = s0_adv && we_raw;

  // allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      high_water <= '0;
      live_count <= '0;
    end else if (s0_adv) begin
      high_water <= high_water_next;
      live_count <= live_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s0_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      m_tdata <= OUT_W'({live_count_next, is_live, status, granted});
    end
  end

  `SFL_ASSERT(a_count_sum, clk, rst, (CNT_W+1)'(live_count) + (CNT_W+1)'(stk_depth) == (CNT_W+1)'(high_water))
  `SFL_ASSERT_NEVER(a_hw_cap, clk, rst, high_water > CNT_W'(CAPACITY))
  `SFL_ASSERT(a_alloc_count, clk, rst, (s0_adv && s0_func == FUNC_ALLOC && status == STAT_OK) |=> (live_count == $past(live_count) + CNT_W'(1)))

endmodule

`default_nettype wire

// ===== hw/rtl/slot_fl_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
// Read data holds while rd_en is low.
module slot_fl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slot_fl_stack.sv =====
`default_nettype none
`include "slot_allocator_free_list_core_assert.svh"

// LIFO of freed slot ids. The top entry lives in a register; the RAM read
// port always looks at the entry just below it, so a pop finds the next top
// ready in the following cycle.
module slot_fl_stack import slot_fl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_W     = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire stack_ctl_t       ctl,
  input  wire logic [ID_W-1:0]  push_id,
  output logic      [ID_W-1:0]  top,
  output logic      [CNT_W-1:0] depth
);

  logic [CNT_W-1:0] depth_next;
  logic [ID_W-1:0]  below;
  logic [ID_W-1:0]  rd_addr;

  // depth update
  always_comb begin
    depth_next = depth;
    if (ctl.clear) begin
      depth_next = '0;
    end else if (ctl.push) begin
      depth_next = depth + CNT_W'(1);
    end else if (ctl.pop) begin
      depth_next = depth - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      depth <= depth_next;
    end
  end

  // cached top of stack
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      top <= push_id;
    end else if (ctl.pop) begin
      top <= below;
    end
  end

  // read the entry under the next top, so it is there next cycle
  assign rd_addr = ID_W'(depth_next - CNT_W'(2));

  slot_fl_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ctl.push),
    .wr_addr (depth[ID_W-1:0]),
    .wr_data (push_id),
    .rd_en   (1'b1),
    .rd_addr (rd_addr),
    .rd_data (below)
  );

  `SFL_ASSERT_NEVER(a_pop_empty, clk, rst, ctl.pop && depth == '0)
  `SFL_ASSERT_NEVER(a_push_full, clk, rst, ctl.push && depth >= CNT_W'(CAPACITY))
  `SFL_ASSERT(a_one_cmd, clk, rst, $onehot0({ctl.push, ctl.pop, ctl.clear}))

endmodule

`default_nettype wire
